[rtl/octree_object_insert_defines.svh]
// Assertion macros shared by the octree insert checker.
`ifndef OCTREE_OBJECT_INSERT_DEFINES_SVH
`define OCTREE_OBJECT_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OOI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OOI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ooi_pkg.sv]
// Shared widths, reset values and register codes of the octree insert block.
`timescale 1ns / 1ps

package ooi_pkg;

  localparam int COORD_W    = 16;  // Q8.8 signed coordinate
  localparam int HW_W       = 15;  // Q7.8 unsigned half width and radius
  localparam int ID_W       = 8;   // object identifier
  localparam int NODE_IDX_W = 10;  // reported node index
  localparam int LEVEL_O_W  = 2;   // reported node level
  localparam int LVL_W      = 3;   // internal level, holds up to the deepest level
  localparam int CTR_W      = 18;  // node center, root plus the sum of halved widths
  localparam int DIFF_W     = 19;  // position minus center
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [HW_W-1:0] ROOT_HW_RST = 15'd12800;  // 50.0

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_X  = 2'd0,
    CFG_ROOT_Y  = 2'd1,
    CFG_ROOT_Z  = 2'd2,
    CFG_ROOT_HW = 2'd3
  } cfg_reg_t;

endpackage

[rtl/octree_object_insert.sv]
// Top level of the fixed-depth octree object insert block.
`timescale 1ns / 1ps

// Octree object insert. Each item (object id, Q8.8 position, radius, collider
// flag) descends a complete octree of TREE_DEPTH+1 levels from the configured
// root: at each node an item with the collider flag set stops when it
// straddles the node on some axis, otherwise the signs of position minus
// center pick the child octant; an item without the flag takes octant 0.
// The item is then prepended to the chosen node's object list, and the
// result reports the node, its level and the previous list head (the next
// link). An item is taken at a clock edge with start high and busy low, one
// item per cycle; its result comes with out_valid high for exactly one cycle,
// and the receiver cannot stall it. The descent runs as one registered
// stage per tree level, then a stage that reads the node head memory and
// one that writes it and registers the result; a head written in the same
// cycle as the next item's read is forwarded. After reset, busy stays high
// for a clearing pass of one memory entry per cycle over all NODE_COUNT
// entries (585 at TREE_DEPTH 3); configuration writes are taken during
// that pass. Write the root registers only while no item is in flight.
module octree_object_insert #(
  parameter int TREE_DEPTH = 3  // 1..4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item input
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ooi_pkg::ID_W-1:0]             in_object_id,
  input  logic signed [ooi_pkg::COORD_W-1:0]   in_pos_x,
  input  logic signed [ooi_pkg::COORD_W-1:0]   in_pos_y,
  input  logic signed [ooi_pkg::COORD_W-1:0]   in_pos_z,
  input  logic [ooi_pkg::HW_W-1:0]             in_radius,
  input  logic                                 in_has_collider,
  // result output
  output logic                                 out_valid,
  output logic [ooi_pkg::NODE_IDX_W-1:0]       out_node_index,
  output logic [ooi_pkg::LEVEL_O_W-1:0]        out_node_level,
  output logic [ooi_pkg::ID_W-1:0]             out_prior_head,
  output logic                                 out_prior_head_valid,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [ooi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ooi_pkg::CFG_W-1:0]            cfg_wdata
);

  import ooi_pkg::*;

  localparam int NODE_COUNT = ((1 << (3 * (TREE_DEPTH + 1))) - 1) / 7;
  localparam int NODE_AW    = $clog2(NODE_COUNT);

  // One descent stage's view of an item.
  typedef struct packed {
    logic                       done;  // stopped at a straddled node
    logic [ID_W-1:0]            id;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
    logic [HW_W-1:0]            rad;
    logic                       col;
    logic signed [CTR_W-1:0]    cx;
    logic signed [CTR_W-1:0]    cy;
    logic signed [CTR_W-1:0]    cz;
    logic [HW_W-1:0]            hw;
    logic [NODE_AW-1:0]         node;
    logic [LVL_W-1:0]           lvl;
  } dsc_t;

  // Test one axis: bit 1 is straddle, bit 0 is position above center.
  function automatic logic [1:0] axis_chk(input logic signed [COORD_W-1:0] p,
                                          input logic signed [CTR_W-1:0]   c,
                                          input logic [HW_W-1:0]           r);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        ad;
    d  = DIFF_W'(p) - DIFF_W'(c);
    ad = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return {(ad < DIFF_W'(r)), (d > 0)};
  endfunction

  // One tree level: stop on a straddle, else move to the chosen child.
  function automatic dsc_t dsc_step(input dsc_t s);
    dsc_t                    n;
    logic [1:0]              ax;
    logic [1:0]              ay;
    logic [1:0]              az;
    logic                    strad;
    logic [2:0]              oct;
    logic [HW_W-1:0]         hwn;
    logic signed [CTR_W-1:0] h;
    n     = s;
    ax    = axis_chk(s.px, s.cx, s.rad);
    ay    = axis_chk(s.py, s.cy, s.rad);
    az    = axis_chk(s.pz, s.cz, s.rad);
    strad = s.col & (ax[1] | ay[1] | az[1]);
    oct   = s.col ? {az[0], ay[0], ax[0]} : 3'b000;
    hwn   = s.hw >> 1;
    h     = CTR_W'(signed'({1'b0, hwn}));
    if (!s.done && !strad) begin
      n.hw   = hwn;
      n.cx   = oct[0] ? s.cx + h : s.cx - h;
      n.cy   = oct[1] ? s.cy + h : s.cy - h;
      n.cz   = oct[2] ? s.cz + h : s.cz - h;
      n.node = NODE_AW'({s.node, 3'b000}) + NODE_AW'(oct) + NODE_AW'(1);
      n.lvl  = s.lvl + LVL_W'(1);
    end
    n.done = s.done | strad;
    return n;
  endfunction

  // Root configuration.
  logic signed [COORD_W-1:0] root_x_r;
  logic signed [COORD_W-1:0] root_y_r;
  logic signed [COORD_W-1:0] root_z_r;
  logic [HW_W-1:0]           root_hw_r;

  // Descent pipeline: entry 0 holds the accepted item, entry l+1 its state
  // after level l.
  dsc_t                pl_r [0:TREE_DEPTH];
  logic [TREE_DEPTH:0] pl_vld_r;

  // Head update stage and result registers.
  logic               q_vld_r;
  logic [ID_W-1:0]    q_id_r;
  logic [NODE_AW-1:0] q_node_r;
  logic [LVL_W-1:0]   q_lvl_r;
  logic [ID_W:0]      rd_r;      // {valid, id} read from the head memory
  logic               fwd_r;     // head was written in the read cycle
  logic [ID_W-1:0]    fwd_id_r;

  logic                  out_valid_r;
  logic [NODE_IDX_W-1:0] out_node_r;
  logic [LEVEL_O_W-1:0]  out_lvl_r;
  logic [ID_W-1:0]       out_head_r;
  logic                  out_head_vld_r;

  // Clearing pass.
  logic               clr_act_r;
  logic [NODE_AW-1:0] clr_cnt_r;

  // Head memory: {valid, object id} per node.
  logic [ID_W:0]      head_mem [0:NODE_COUNT-1];
  logic               mem_we;
  logic [NODE_AW-1:0] mem_wa;
  logic [ID_W:0]      mem_wd;

  logic                     accept;
  dsc_t                     entry;
  logic                     hd_vld;
  logic [ID_W-1:0]          hd_id;
  logic [NODE_AW+NODE_IDX_W-1:0] node_ext;

  assign busy   = clr_act_r;
  assign accept = start & ~clr_act_r;

  // Seed an accepted item at the root.
  always_comb begin
    entry      = '0;
    entry.id   = in_object_id;
    entry.px   = in_pos_x;
    entry.py   = in_pos_y;
    entry.pz   = in_pos_z;
    entry.rad  = in_radius;
    entry.col  = in_has_collider;
    entry.cx   = CTR_W'(root_x_r);
    entry.cy   = CTR_W'(root_y_r);
    entry.cz   = CTR_W'(root_z_r);
    entry.hw   = root_hw_r;
  end

  // Take configuration writes at any time; unknown codes cannot occur.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_x_r  <= '0;
      root_y_r  <= '0;
      root_z_r  <= '0;
      root_hw_r <= ROOT_HW_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROOT_X:  root_x_r  <= cfg_wdata;
        CFG_ROOT_Y:  root_y_r  <= cfg_wdata;
        CFG_ROOT_Z:  root_z_r  <= cfg_wdata;
        CFG_ROOT_HW: root_hw_r <= cfg_wdata[HW_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the descent and update stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_vld_r    <= '0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pl_vld_r    <= {pl_vld_r[TREE_DEPTH-1:0], accept};
      q_vld_r     <= pl_vld_r[TREE_DEPTH];
      out_valid_r <= q_vld_r;
    end
  end

  // Advance the descent one level per stage.
  always_ff @(posedge clk) begin
    pl_r[0] <= entry;
    for (int l = 0; l < TREE_DEPTH; l++) begin
      pl_r[l+1] <= dsc_step(pl_r[l]);
    end
  end

  // Sweep every entry to empty after reset, holding off items meanwhile.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_act_r) begin
      clr_cnt_r <= clr_cnt_r + NODE_AW'(1);
      if (clr_cnt_r == NODE_AW'(NODE_COUNT - 1)) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  // One write port: the clearing pass or the head update of the item in q.
  assign mem_we = clr_act_r | q_vld_r;
  assign mem_wa = clr_act_r ? clr_cnt_r : q_node_r;
  assign mem_wd = clr_act_r ? '0 : {1'b1, q_id_r};

  // Read the head of the leaving item's node; the item in q writes the
  // same cycle, so forward its id when both hit one node.
  always_ff @(posedge clk) begin
    rd_r     <= head_mem[pl_r[TREE_DEPTH].node];
    fwd_r    <= q_vld_r && (q_node_r == pl_r[TREE_DEPTH].node);
    fwd_id_r <= q_id_r;
    q_id_r   <= pl_r[TREE_DEPTH].id;
    q_node_r <= pl_r[TREE_DEPTH].node;
    q_lvl_r  <= pl_r[TREE_DEPTH].lvl;
    if (mem_we) begin
      head_mem[mem_wa] <= mem_wd;
    end
  end

  assign hd_vld   = fwd_r | rd_r[ID_W];
  assign hd_id    = fwd_r ? fwd_id_r : rd_r[ID_W-1:0];
  assign node_ext = {{NODE_IDX_W{1'b0}}, q_node_r};

  // Register the result; report index and level in their field widths.
  always_ff @(posedge clk) begin
    out_node_r     <= node_ext[NODE_IDX_W-1:0];
    out_lvl_r      <= q_lvl_r[LEVEL_O_W-1:0];
    out_head_r     <= hd_vld ? hd_id : '0;
    out_head_vld_r <= hd_vld;
  end

  assign out_valid            = out_valid_r;
  assign out_node_index       = out_node_r;
  assign out_node_level       = out_lvl_r;
  assign out_prior_head       = out_head_r;
  assign out_prior_head_valid = out_head_vld_r;

endmodule

[rtl/ooi_checker.sv]
// Port-level assertions for the octree insert block, bound to its top level.
`timescale 1ns / 1ps
`include "octree_object_insert_defines.svh"

module ooi_checker #(
  parameter int TREE_DEPTH = 3
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           busy,
  input logic                           out_valid,
  input logic [ooi_pkg::NODE_IDX_W-1:0] out_node_index,
  input logic [ooi_pkg::LEVEL_O_W-1:0]  out_node_level,
  input logic [ooi_pkg::ID_W-1:0]       out_prior_head,
  input logic                           out_prior_head_valid
);

  import ooi_pkg::*;

  // Clearing pass runs once after reset.
  `OOI_ASSERT_NEXT(a_busy_once, !busy, !busy, "busy rose after the clearing pass")
  // No item can be in flight while clearing.
  `OOI_ASSERT_NOW(a_no_out_busy, busy, !out_valid, "result during clearing pass")
  // An empty list reports a zero link.
  `OOI_ASSERT_NOW(a_empty_head, out_valid && !out_prior_head_valid,
                  out_prior_head == '0, "nonzero head for an empty list")
  // Level zero is the root, unless the level field wraps.
  `OOI_ASSERT_NOW(a_root_index, (TREE_DEPTH < 4) && out_valid && (out_node_level == '0),
                  out_node_index == '0, "root level with nonzero node index")

endmodule

bind octree_object_insert ooi_checker #(.TREE_DEPTH(TREE_DEPTH)) u_ooi_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_node_index       (out_node_index),
  .out_node_level       (out_node_level),
  .out_prior_head       (out_prior_head),
  .out_prior_head_valid (out_prior_head_valid)
);

[tb/sv/tb_octree_object_insert.sv]
// Self-checking testbench for the fixed-depth octree object insert block.
`timescale 1ns / 1ps

module tb_octree_object_insert;
  import ooi_pkg::*;

  localparam int TREE_DEPTH = 3;
  localparam int NODE_TOTAL = ((1 << (3 * (TREE_DEPTH + 1))) - 1) / 7;  // 585
  localparam int LATENCY    = TREE_DEPTH + 3;
  // Longest quiet stretch of a correct run is the clearing pass after reset,
  // and MAX_GAP caps the idle gap a sender leaves before an item.
  localparam int MAX_GAP    = 20;
  localparam int QUIET_MAX  = 4 * (NODE_TOTAL + MAX_GAP + LATENCY + 16);

  typedef struct {
    logic [ID_W-1:0]           object_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [HW_W-1:0]           radius;
    logic                      has_collider;
  } object_t;

  typedef struct {
    logic [NODE_IDX_W-1:0] node_index;
    logic [LEVEL_O_W-1:0]  node_level;
    logic [ID_W-1:0]       prior_head;
    logic                  prior_head_valid;
  } placement_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [ID_W-1:0]           in_object_id;
  logic signed [COORD_W-1:0] in_pos_x;
  logic signed [COORD_W-1:0] in_pos_y;
  logic signed [COORD_W-1:0] in_pos_z;
  logic [HW_W-1:0]           in_radius;
  logic                      in_has_collider;
  logic                      out_valid;
  logic [NODE_IDX_W-1:0]     out_node_index;
  logic [LEVEL_O_W-1:0]      out_node_level;
  logic [ID_W-1:0]           out_prior_head;
  logic                      out_prior_head_valid;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;

  octree_object_insert #(.TREE_DEPTH(TREE_DEPTH)) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_object_id         (in_object_id),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_pos_z             (in_pos_z),
    .in_radius            (in_radius),
    .in_has_collider      (in_has_collider),
    .out_valid            (out_valid),
    .out_node_index       (out_node_index),
    .out_node_level       (out_node_level),
    .out_prior_head       (out_prior_head),
    .out_prior_head_valid (out_prior_head_valid),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // Shadow copy of the root registers and of the node list heads.
  int               root_ctr [3];
  int               root_hw;
  bit               head_valid [NODE_TOTAL];
  logic [ID_W-1:0]  head_id [NODE_TOTAL];

  placement_t pending_q [$];  // predicted placements, oldest first

  int objects_sent;
  int placements_seen;
  int reg_writes;
  int mismatches;
  int level_hits [4];
  int quiet_cycles;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk the octree the way the block does and prepend the object to the
  // chosen node's list; return the node and the list head it displaced.
  function automatic placement_t place_object(input object_t o);
    placement_t r;
    int         pos [3];
    int         ctr [3];
    int         hw;
    int         node;
    int         lvl;
    int         oct;
    int         d;
    int         ad;
    int         a;
    bit         stop;
    pos[0] = o.pos_x;
    pos[1] = o.pos_y;
    pos[2] = o.pos_z;
    ctr    = root_ctr;
    hw     = root_hw;
    node   = 0;
    lvl    = 0;
    stop   = 1'b0;
    while (lvl < TREE_DEPTH && !stop) begin
      oct = 0;
      // Test axes x, y, z in order; the first straddling axis ends the walk.
      if (o.has_collider) begin
        for (a = 0; a < 3 && !stop; a++) begin
          d  = pos[a] - ctr[a];
          ad = (d < 0) ? -d : d;
          if (ad < int'(o.radius))
            stop = 1'b1;
          else if (d > 0)
            oct |= (1 << a);
        end
      end
      if (!stop) begin
        hw = hw >>> 1;
        for (a = 0; a < 3; a++)
          ctr[a] += ((oct >> a) & 1) ? hw : -hw;
        node = 8 * node + 1 + oct;
        lvl++;
      end
    end
    if (node >= NODE_TOTAL)
      node = 0;
    r.node_index       = node[NODE_IDX_W-1:0];
    r.node_level       = lvl[LEVEL_O_W-1:0];
    r.prior_head       = head_valid[node] ? head_id[node] : '0;
    r.prior_head_valid = head_valid[node];
    head_valid[node]   = 1'b1;
    head_id[node]      = o.object_id;
    level_hits[lvl]++;
    return r;
  endfunction

  function automatic object_t make_object(input int id, input int x, input int y,
                                          input int z, input int rad, input bit coll);
    object_t o;
    o.object_id    = id[ID_W-1:0];
    o.pos_x        = x[COORD_W-1:0];
    o.pos_y        = y[COORD_W-1:0];
    o.pos_z        = z[COORD_W-1:0];
    o.radius       = rad[HW_W-1:0];
    o.has_collider = coll;
    return o;
  endfunction

  function automatic int clip_coord(input int v);
    if (v > 32767)
      return 32767;
    if (v < -32768)
      return -32768;
    return v;
  endfunction

  // Most objects land near the root with a radius small against the half
  // width, so they reach the deeper levels; the rest are raw noise.
  function automatic object_t random_object();
    object_t o;
    int      h;
    int      p [3];
    int      rad;
    int      a;
    h = (root_hw < 1) ? 1 : root_hw;
    if ($urandom_range(99) < 25) begin
      o.object_id    = ID_W'($urandom);
      o.pos_x        = COORD_W'($urandom);
      o.pos_y        = COORD_W'($urandom);
      o.pos_z        = COORD_W'($urandom);
      o.radius       = HW_W'($urandom);
      o.has_collider = 1'($urandom);
      return o;
    end
    for (a = 0; a < 3; a++)
      p[a] = clip_coord(root_ctr[a] + int'($urandom_range(0, 4 * h + 2)) - 2 * h - 1);
    case ($urandom_range(3))
      0:       rad = 0;
      1:       rad = $urandom_range(0, 32767);
      default: rad = $urandom_range(0, (h / 4 > 0) ? h / 4 : 1);
    endcase
    return make_object($urandom_range(0, 255), p[0], p[1], p[2], rad,
                       $urandom_range(99) < 90);
  endfunction

  // Present one item, hold it until taken, then record its placement.
  task automatic send_object(input object_t o, input int idle_pct);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_object_id    = o.object_id;
    in_pos_x        = o.pos_x;
    in_pos_y        = o.pos_y;
    in_pos_z        = o.pos_z;
    in_radius       = o.radius;
    in_has_collider = o.has_collider;
    start           = 1'b1;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    pending_q.push_back(place_object(o));
    objects_sent++;
  endtask

  // Drop start and wait until every predicted placement has come back.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ROOT_X:  root_ctr[0] = int'(signed'(value));
      CFG_ROOT_Y:  root_ctr[1] = int'(signed'(value));
      CFG_ROOT_Z:  root_ctr[2] = int'(signed'(value));
      CFG_ROOT_HW: root_hw     = int'(value[HW_W-1:0]);
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_root(input int x, input int y, input int z, input int hw_raw);
    write_reg(CFG_ROOT_X, x[CFG_W-1:0]);
    write_reg(CFG_ROOT_Y, y[CFG_W-1:0]);
    write_reg(CFG_ROOT_Z, z[CFG_W-1:0]);
    write_reg(CFG_ROOT_HW, hw_raw[CFG_W-1:0]);
  endtask

  // Hand-picked objects under the reset root (center 0, half width 50.0).
  task automatic test_directed_placement();
    // Zero radius at the exact center: no straddle, octant 0 at the root and octant 7 below it, down to a leaf.
    send_object(make_object(0, 0, 0, 0, 0, 1), 0);
    // Zero distance below a radius of one LSB: straddles the root.
    send_object(make_object(255, 0, 0, 0, 1, 1), 0);
    // Corner positions with zero radius reach the outer leaves.
    send_object(make_object(1, 32767, 32767, 32767, 0, 1), 0);
    send_object(make_object(2, -32768, -32768, -32768, 0, 1), 0);
    // Largest radius: passes the root only where the distance equals or
    // exceeds it, then straddles the first level.
    send_object(make_object(3, 32767, 32767, 32767, 32767, 1), 0);
    send_object(make_object(4, -32768, -32768, -32768, 32767, 1), 0);
    send_object(make_object(5, 0, 0, 0, 32767, 1), 0);
    // Straddle at level one (30.0 against a child center of 25.0, r 10.0).
    send_object(make_object(8, 7680, 7680, 7680, 2560, 1), 0);
    // Straddle at level two (40.0 against 37.5, r 3.0), mixed octant signs.
    send_object(make_object(9, 10240, -10240, 10240, 768, 1), 0);
    // Distance equal to the radius does not straddle.
    send_object(make_object(10, 2560, -20000, 20000, 2560, 1), 0);
    // No collider: octant 0 to a leaf regardless of position and radius;
    // the second and third hit the same list and see the previous head.
    send_object(make_object(6, 12345, -31000, 999, 32767, 0), 0);
    send_object(make_object(7, -7, 7, -7, 100, 0), 0);
    send_object(make_object(7, 30000, 30000, 30000, 0, 0), 0);
    // Only y straddles, then only z straddles.
    send_object(make_object(11, 20000, 100, 20000, 256, 1), 0);
    send_object(make_object(12, -20000, -20000, 0, 256, 1), 0);
    // Negative differences leave their octant bits clear.
    send_object(make_object(13, -5000, 5000, -5000, 0, 1), 0);
    drain();
  endtask

  // Extreme root settings, including a half width that masks down to zero.
  task automatic test_register_extremes();
    int s;
    int n;
    for (s = 0; s < 4; s++) begin
      case (s)
        0: set_root(-32768, 32767, 0, 1);
        1: set_root(32767, -32768, -32768, 32767);
        2: set_root(0, 0, 0, 'h8000);        // half width 0: centers coincide
        3: set_root(-1, 1, -256, 'hFFFF);    // bit 15 of the data is dropped
        default: ;
      endcase
      send_object(make_object($urandom_range(0, 255), root_ctr[0], root_ctr[1],
                              root_ctr[2], 0, 1), 10);
      send_object(make_object($urandom_range(0, 255), root_ctr[0], root_ctr[1],
                              root_ctr[2], 1, 1), 10);
      for (n = 0; n < 4; n++)
        send_object(random_object(), 10);
      drain();
    end
  endtask

  // Random insertion under a random root, sender idling at idle_pct.
  task automatic test_random_insertion(input int idle_pct, input int count);
    int n;
    int hw_raw;
    if ($urandom_range(3) == 0)
      hw_raw = $urandom;
    else
      hw_raw = int'({1'($urandom_range(0, 1)), 15'($urandom_range(64, 12800))});
    set_root($urandom, $urandom, $urandom, hw_raw);
    for (n = 0; n < count; n++)
      send_object(random_object(), idle_pct);
    drain();
  endtask

  // Compare every result against the oldest predicted placement.
  always @(posedge clk) begin
    placement_t exp_p;
    if (rst_n && out_valid) begin
      placements_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: node_index %0d", out_node_index);
        mismatches++;
      end else begin
        exp_p = pending_q.pop_front();
        if (out_node_index !== exp_p.node_index) begin
          $error("node_index expected %0d got %0d", exp_p.node_index, out_node_index);
          mismatches++;
        end
        if (out_node_level !== exp_p.node_level) begin
          $error("node_level expected %0d got %0d", exp_p.node_level, out_node_level);
          mismatches++;
        end
        if (out_prior_head !== exp_p.prior_head) begin
          $error("prior_head expected %0d got %0d", exp_p.prior_head, out_prior_head);
          mismatches++;
        end
        if (out_prior_head_valid !== exp_p.prior_head_valid) begin
          $error("prior_head_valid expected %0d got %0d", exp_p.prior_head_valid,
                 out_prior_head_valid);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_object_id    = '0;
    in_pos_x        = '0;
    in_pos_y        = '0;
    in_pos_z        = '0;
    in_radius       = '0;
    in_has_collider = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_ROOT_X;
    cfg_wdata       = '0;
    objects_sent    = 0;
    placements_seen = 0;
    reg_writes      = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    level_hits      = '{default: 0};
    root_ctr        = '{default: 0};
    root_hw         = int'(ROOT_HW_RST);
    for (n = 0; n < NODE_TOTAL; n++) begin
      head_valid[n] = 1'b0;
      head_id[n]    = '0;
    end

    // Hold reset, then release it on a falling edge.
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed_placement();
    test_register_extremes();
    test_random_insertion(23, 125);
    test_random_insertion(55, 125);
    test_random_insertion(0, 125);

    // Let any stray result show up before the verdict.
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d insertions and %0d root register writes, %0d results checked",
             objects_sent, reg_writes, placements_seen);
    $display("placements per level 0..3: %0d %0d %0d %0d",
             level_hits[0], level_hits[1], level_hits[2], level_hits[3]);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
